// ===== rtl/chtr_pkg.sv =====
// chtr_pkg: shared types and constants for the clustered hash table.
// No dependencies.
`timescale 1ns / 1ps
package chtr_pkg;

  localparam logic [1:0] CMD_PROBE  = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam logic CFG_GEN  = 1'b0;
  localparam logic CFG_MASK = 1'b1;

  localparam int GEN_W  = 8;
  localparam int MASK_W = 12;
  localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        position_key;
    logic signed [15:0] score;
    logic [1:0]         bound_kind;
    logic signed [15:0] search_depth;
    logic [31:0]        best_move;
    logic signed [15:0] static_eval;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] found_score;
    logic [1:0]         found_bound;
    logic signed [15:0] found_depth;
    logic [31:0]        found_move;
    logic signed [15:0] found_eval;
    logic [7:0]         found_age;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic signed [15:0] eval;
    logic [1:0]         bound;
    logic [7:0]         age;
    logic signed [15:0] depth;
  } entry_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL,
    ST_CLR
  } state_t;

endpackage

// ===== rtl/chtr_front.sv =====
// chtr_front: input acceptance, cluster index computation and a two-word queue.
// Depends on chtr_pkg.
`timescale 1ns / 1ps
module chtr_front
  import chtr_pkg::*;
#(
  parameter int CLUSTER_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_word_t                in_word,
  input  logic [MASK_W-1:0]       cluster_mask,
  output logic                    q_valid,
  input  logic                    q_pop,
  output in_word_t                q_word,
  output logic [CLUSTER_BITS-1:0] q_idx
);

  in_word_t                qw [2];
  logic [CLUSTER_BITS-1:0] qi [2];
  logic                    rd_ptr;
  logic                    wr_ptr;
  logic [1:0]              cnt;
  logic                    push;
  logic [CLUSTER_BITS+MASK_W-1:0] mask_z;
  logic [CLUSTER_BITS-1:0] idx;

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign mask_z   = {{CLUSTER_BITS{1'b0}}, cluster_mask};
  assign idx      = in_word.position_key[CLUSTER_BITS-1:0] & mask_z[CLUSTER_BITS-1:0];

  assign q_valid = (cnt != 2'd0);
  assign q_word  = qw[rd_ptr];
  assign q_idx   = qi[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qw[wr_ptr] <= in_word;
      qi[wr_ptr] <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/chtr_back.sv =====
// chtr_back: cluster memory, probe/store/clear sequencer and output register.
// Depends on chtr_pkg.
`timescale 1ns / 1ps
module chtr_back
  import chtr_pkg::*;
#(
  parameter int WAYS         = 4,
  parameter int CLUSTER_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  in_word_t                q_word,
  input  logic [CLUSTER_BITS-1:0] q_idx,
  input  logic [GEN_W-1:0]        search_generation,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_word_t               out_word
);

  localparam int WB   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROWS = 1 << CLUSTER_BITS;

  entry_t [WAYS-1:0] mem [ROWS];
  entry_t [WAYS-1:0] rd_row;
  entry_t [WAYS-1:0] new_row;
  entry_t [WAYS-1:0] mem_wdata;
  logic                    mem_we;
  logic [CLUSTER_BITS-1:0] mem_waddr;

  state_t state, state_next;
  in_word_t                cur;
  logic [CLUSTER_BITS-1:0] cur_idx;
  logic [CLUSTER_BITS-1:0] clr_cnt;
  logic                    clr_last;
  logic                    slot_free;
  logic                    res_set;
  out_word_t               res;

  logic          hit_f;
  logic [WB-1:0] hit_w;
  logic          free_f;
  logic [WB-1:0] free_w;
  logic [WB-1:0] rep;
  logic [WB-1:0] tgt;
  logic [31:0]   mv;
  logic          a, b, c;

  assign slot_free = !out_valid || out_ready;
  assign clr_last  = (clr_cnt == {CLUSTER_BITS{1'b1}});

  always_comb begin
    hit_f = 1'b0;
    hit_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_f && rd_row[w].tag == cur.position_key[63:32]) begin
        hit_f = 1'b1;
        hit_w = WB'(w);
      end
    end
  end

  always_comb begin
    free_f = 1'b0;
    free_w = '0;
    rep    = '0;
    a = 1'b0;
    b = 1'b0;
    c = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!free_f) begin
        if (rd_row[w].tag == 32'd0 || rd_row[w].tag == cur.position_key[63:32]) begin
          free_f = 1'b1;
          free_w = WB'(w);
        end else begin
          a = (rd_row[rep].age == search_generation);
          b = (rd_row[w].age == search_generation) || (rd_row[w].bound == BOUND_EXACT);
          c = (rd_row[w].depth < rd_row[rep].depth);
          if ((a && !b) || (c && (a == b))) rep = WB'(w);
        end
      end
    end
    tgt = free_f ? free_w : rep;
    mv  = (free_f && cur.best_move == 32'd0) ? rd_row[free_w].move : cur.best_move;
  end

  always_comb begin
    new_row = rd_row;
    new_row[tgt].tag   = cur.position_key[63:32];
    new_row[tgt].score = cur.score;
    new_row[tgt].move  = mv;
    new_row[tgt].eval  = cur.static_eval;
    new_row[tgt].bound = cur.bound_kind;
    new_row[tgt].age   = search_generation;
    new_row[tgt].depth = cur.search_depth;
  end

  always_comb begin
    res = '0;
    if (state == ST_EVAL && cur.cmd == CMD_PROBE && hit_f) begin
      res.hit         = 1'b1;
      res.found_score = rd_row[hit_w].score;
      res.found_bound = rd_row[hit_w].bound;
      res.found_depth = rd_row[hit_w].depth;
      res.found_move  = rd_row[hit_w].move;
      res.found_eval  = rd_row[hit_w].eval;
      res.found_age   = rd_row[hit_w].age;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          state_next = (q_word.cmd == CMD_CLEAR) ? ST_CLR : ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_IDLE;
      ST_CLR:  if (clr_last) state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = new_row;
    res_set   = 1'b0;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: q_pop = q_valid && slot_free;
      ST_EVAL: begin
        mem_we  = (cur.cmd == CMD_STORE);
        res_set = 1'b1;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
        res_set   = clr_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_row <= mem[q_idx];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_word;
      cur_idx <= q_idx;
    end
    if (res_set) out_word <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLR) clr_cnt <= clr_cnt + 1'b1;
      if (res_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_eval_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> !out_valid) else $error("eval with output slot busy");
  a_eval_gives_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |=> out_valid) else $error("eval did not load output");
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT || state == ST_CLR) |-> !q_pop) else $error("pop during clear");
  a_sweep_from_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) == ST_CLR) |-> clr_cnt == '0)
    else $error("clear sweep ended early");

endmodule

// ===== rtl/clustered_hash_table_with_replacement_top.sv =====
// Clustered hash table top: configuration registers, front queue, back sequencer.
// A probe/store is popped from the queue in IDLE once the output slot is free, reading its
// cluster row; EVAL then writes the row back for a store and loads the output register.
// Clear sweeps all 2^CLUSTER_BITS rows, one row per cycle. After reset the same sweep
// runs before any word is processed; the input queue still takes up to two words.
`timescale 1ns / 1ps
module clustered_hash_table_with_replacement_top
  import chtr_pkg::*;
#(
  parameter int WAYS         = 4,
  parameter int CLUSTER_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MASK_W-1:0] cfg_data
);

  logic [GEN_W-1:0]        search_generation;
  logic [MASK_W-1:0]       cluster_mask;
  logic                    q_valid;
  logic                    q_pop;
  in_word_t                q_word;
  logic [CLUSTER_BITS-1:0] q_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_generation <= '0;
      cluster_mask      <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GEN:  search_generation <= cfg_data[GEN_W-1:0];
        CFG_MASK: cluster_mask      <= cfg_data;
        default: ;
      endcase
    end
  end

  chtr_front #(.CLUSTER_BITS(CLUSTER_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .cluster_mask (cluster_mask),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_word       (q_word),
    .q_idx        (q_idx)
  );

  chtr_back #(.WAYS(WAYS), .CLUSTER_BITS(CLUSTER_BITS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_word            (q_word),
    .q_idx             (q_idx),
    .search_generation (search_generation),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (out_word)
  );

endmodule
